[rtl/core/cvd_pkg.sv]
// ----------------------------------------------------------------------------
// cvd_pkg
// Shared types and constants for the column VIL and density block.
// ----------------------------------------------------------------------------
package cvd_pkg;

  // field widths
  localparam int CODE_W    = 16;
  localparam int SCALE_W   = 10;
  localparam int HEIGHT_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIL_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIL_MISSING   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DENS_MISSING  = 2'd3;

  localparam logic [SCALE_W-1:0]       VIL_GAIN_RST      = 10'd10;
  localparam logic [SCALE_W-1:0]       DENSITY_SCALE_RST = 10'd10;
  localparam logic signed [CODE_W-1:0] MISSING_RST       = -16'sd9990;
  localparam logic signed [CODE_W-1:0] CODE_MAX          = 16'sd32767;

  // reflectivity limits in tenths of dBZ
  localparam logic signed [15:0] ECHO_FLOOR_TENTHS = 16'sd50;
  localparam logic signed [15:0] ECHO_CEIL_TENTHS  = 16'sd550;

  // power table and its build sweep
  localparam int TABLE_DEPTH = 512;
  localparam int TABLE_AW    = 9;
  localparam int FILL_W      = 10;
  localparam logic [FILL_W-1:0] FILL_FIRST = 10'd50;
  localparam logic [FILL_W-1:0] FILL_LAST  = 10'd561;
  localparam logic [7:0]  STEPS_LAST    = 8'd174;
  localparam logic [25:0] STEP_FRACTION = 26'd56885002;
  localparam int P_W = 44;

  // output scaling
  localparam int VIL_MULT  = 43;
  localparam int VIL_DIV   = 12500000;
  localparam int DENS_DIV  = 12500;
  localparam int QUO_BITS  = 15;

  localparam logic SEL_VIL  = 1'b0;
  localparam logic SEL_DENS = 1'b1;

  typedef struct packed {
    logic fill;
    logic accept;
    logic mul;
    logic acc;
    logic prep;
    logic mstart;
    logic mstart_dens;
    logic mstep;
    logic dstart;
    logic dsat;
    logic dstep;
    logic save;
    logic emit;
    logic sel;
  } cvd_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic item_last;
    logic echo_found;
    logic sum_pos;
    logic used_pos;
  } cvd_status_t;

  function automatic logic [9:0] pow10(input logic [1:0] q);
    logic [9:0] v;
    case (q)
      2'd0:    v = 10'd1;
      2'd1:    v = 10'd10;
      2'd2:    v = 10'd100;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/cvd_ram.sv]
// ----------------------------------------------------------------------------
// cvd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/cvd_ctrl.sv]
// ----------------------------------------------------------------------------
// cvd_ctrl
// Sequencer: table build, per-level steps and the column-end scaling.
// ----------------------------------------------------------------------------
module cvd_ctrl
  import cvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  cvd_status_t st,
  output cvd_cmd_t    cmd
);

  localparam logic [3:0] ST_FILL = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_LOOK = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_PREP = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_DRND = 4'd6;
  localparam logic [3:0] ST_DSAT = 4'd7;
  localparam logic [3:0] ST_DDIV = 4'd8;
  localparam logic [3:0] ST_SAVE = 4'd9;
  localparam logic [3:0] ST_EMIT = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  cvd_cmd_t         cmd_c;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_c         = '0;
    cmd_c.sel     = sel_r;
    unique case (state_r)
      ST_FILL: begin
        cmd_c.fill = 1'b1;
        if (st.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_c.accept = 1'b1;
          state_nxt    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_c.mul = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd_c.acc = 1'b1;
        state_nxt = st.item_last ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        if (st.echo_found && st.sum_pos) begin
          cmd_c.prep   = 1'b1;
          cmd_c.mstart = 1'b1;
          sel_nxt      = SEL_VIL;
          cnt_nxt      = CNT_W'(SCALE_W - 1);
          state_nxt    = ST_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd_c.mstep = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DRND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DRND: begin
        cmd_c.dstart = 1'b1;
        state_nxt    = ST_DSAT;
      end
      ST_DSAT: begin
        cmd_c.dsat = 1'b1;
        cnt_nxt    = CNT_W'(QUO_BITS - 1);
        state_nxt  = ST_DDIV;
      end
      ST_DDIV: begin
        cmd_c.dstep = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAVE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SAVE: begin
        cmd_c.save = 1'b1;
        if (sel_r == SEL_VIL && st.used_pos) begin
          cmd_c.mstart      = 1'b1;
          cmd_c.mstart_dens = 1'b1;
          sel_nxt           = SEL_DENS;
          cnt_nxt           = CNT_W'(SCALE_W - 1);
          state_nxt         = ST_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          cmd_c.emit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      sel_r       <= SEL_VIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign cmd       = cmd_c;

endmodule

[rtl/core/cvd_datapath.sv]
// ----------------------------------------------------------------------------
// cvd_datapath
// Power table build, per-level accumulation, serial scaling and division.
// ----------------------------------------------------------------------------
module cvd_datapath
  import cvd_pkg::*;
#(
  parameter int MAX_LEVELS          = 32,
  parameter int POWER_FRACTION_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cvd_cmd_t                   cmd,
  output cvd_status_t                st,
  input  logic signed [CODE_W-1:0]   in_dbz_tenths,
  input  logic [HEIGHT_W-1:0]        in_level_height_m,
  input  logic [HEIGHT_W-1:0]        in_terrain_height_m,
  input  logic                       in_last_level,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CODE_W-1:0]          cfg_data,
  output logic signed [CODE_W-1:0]   out_vil_code,
  output logic signed [CODE_W-1:0]   out_density_code,
  output logic                       out_vil_present,
  output logic                       out_density_present
);

  localparam int PW_W  = 11 + POWER_FRACTION_BITS;
  localparam int LC_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int THK_W = 17 + $clog2(MAX_LEVELS);
  localparam int SUM_W = PW_W + 1 + THK_W;
  localparam int S43_W = SUM_W + 5;
  localparam int NUM_W = S43_W + SCALE_W;
  localparam int DEN_W = 24 + POWER_FRACTION_BITS + THK_W;
  localparam int REM_A = NUM_W + 1;
  localparam int REM_B = DEN_W + QUO_BITS;
  localparam int REM_W = (REM_A > REM_B) ? REM_A : REM_B;
  localparam int RSH   = 32 - POWER_FRACTION_BITS;
  localparam logic [LC_W-1:0] LC_LAST = LC_W'(MAX_LEVELS - 1);

  // configuration
  logic [SCALE_W-1:0]       vil_gain_r, density_scale_r;
  logic signed [CODE_W-1:0] vil_miss_r, dens_miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vil_gain_r      <= VIL_GAIN_RST;
      density_scale_r <= DENSITY_SCALE_RST;
      vil_miss_r      <= MISSING_RST;
      dens_miss_r     <= MISSING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIL_GAIN:      vil_gain_r      <= cfg_data[SCALE_W-1:0];
        CFG_DENSITY_SCALE: density_scale_r <= cfg_data[SCALE_W-1:0];
        CFG_VIL_MISSING:   vil_miss_r      <= cfg_data;
        CFG_DENS_MISSING:  dens_miss_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // power table build: 10^(t/175) by repeated multiply, one step per cycle
  logic [FILL_W-1:0]   fill_t_r;
  logic [7:0]          fill_r_r;
  logic [1:0]          fill_q_r;
  logic [P_W-1:0]      p_r;
  logic [37:0]         hi_prod;
  logic [57:0]         lo_prod;
  logic [P_W-1:0]      p_step;
  logic [P_W-1:0]      p_round;
  logic [1:0]          fill_q_inc;

  assign hi_prod    = p_r[P_W-1:32] * STEP_FRACTION;
  assign lo_prod    = p_r[31:0] * STEP_FRACTION;
  assign p_step     = p_r + P_W'(hi_prod) + P_W'(lo_prod[57:32]);
  assign p_round    = (p_r + (P_W'(1) << (RSH - 1))) >> RSH;
  assign fill_q_inc = fill_q_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_t_r <= '0;
      fill_r_r <= '0;
      fill_q_r <= '0;
      p_r      <= P_W'({pow10(2'd0), 32'd0});
    end else if (cmd.fill) begin
      fill_t_r <= fill_t_r + 1'b1;
      if (fill_r_r == STEPS_LAST) begin
        fill_r_r <= '0;
        fill_q_r <= fill_q_inc;
        p_r      <= P_W'({pow10(fill_q_inc), 32'd0});
      end else begin
        fill_r_r <= fill_r_r + 1'b1;
        p_r      <= p_step;
      end
    end
  end

  logic                dbz_echo;
  logic signed [15:0]  dbz_clip;
  logic [TABLE_AW-1:0] tbl_raddr;
  logic [PW_W-1:0]     pw;

  assign dbz_echo  = (in_dbz_tenths > ECHO_FLOOR_TENTHS);
  assign dbz_clip  = (in_dbz_tenths > ECHO_CEIL_TENTHS) ? ECHO_CEIL_TENTHS : in_dbz_tenths;
  assign tbl_raddr = TABLE_AW'(dbz_clip - ECHO_FLOOR_TENTHS);

  cvd_ram #(
    .WIDTH(PW_W),
    .DEPTH(TABLE_DEPTH)
  ) u_power (
    .clk  (clk),
    .we   (cmd.fill && (fill_t_r >= FILL_FIRST)),
    .waddr(TABLE_AW'(fill_t_r - FILL_FIRST)),
    .wdata(p_round[PW_W-1:0]),
    .raddr(tbl_raddr),
    .rdata(pw)
  );

  // column state
  logic [HEIGHT_W-1:0]     prev_r;
  logic [LC_W-1:0]         lvl_cnt_r;
  logic                    any_r;
  logic                    echo_r;
  logic signed [THK_W-1:0] pending_r;
  logic signed [THK_W-1:0] used_r;
  logic signed [SUM_W-1:0] sum_r;

  // current level
  logic signed [THK_W-1:0] m_r;
  logic                    echo_item_r;
  logic                    last_item_r;
  logic signed [SUM_W-1:0] prod_r;

  logic                    lvl_last;
  logic                    counted;
  logic signed [15:0]      thick;
  logic signed [THK_W-1:0] thick_ext;
  logic signed [THK_W-1:0] thick_c;
  logic signed [THK_W-1:0] m_c;

  assign lvl_last  = in_last_level || (lvl_cnt_r == LC_LAST);
  assign counted   = any_r || (in_level_height_m >= in_terrain_height_m) || lvl_last;
  assign thick     = $signed({1'b0, in_level_height_m}) - $signed({1'b0, prev_r});
  assign thick_ext = {{(THK_W-16){thick[15]}}, thick};
  assign thick_c   = counted ? thick_ext : '0;
  // pending is zero once the lowest echo is found
  assign m_c       = pending_r + thick_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      lvl_cnt_r <= '0;
      any_r     <= 1'b0;
      echo_r    <= 1'b0;
      pending_r <= '0;
      used_r    <= '0;
      sum_r     <= '0;
    end else if (cmd.emit) begin
      prev_r    <= '0;
      lvl_cnt_r <= '0;
      any_r     <= 1'b0;
      echo_r    <= 1'b0;
      pending_r <= '0;
      used_r    <= '0;
      sum_r     <= '0;
    end else begin
      if (cmd.accept) begin
        prev_r    <= in_level_height_m;
        lvl_cnt_r <= lvl_cnt_r + 1'b1;
        if (counted) begin
          any_r <= 1'b1;
        end
        if (dbz_echo) begin
          echo_r    <= 1'b1;
          used_r    <= used_r + m_c;
          pending_r <= '0;
        end else if (counted && !echo_r) begin
          pending_r <= pending_r + thick_ext;
        end
      end
      if (cmd.acc && echo_item_r) begin
        sum_r <= sum_r + prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      m_r         <= m_c;
      echo_item_r <= dbz_echo;
      last_item_r <= lvl_last;
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, pw}) * m_r;
    end
  end

  // column end: serial scale multiply, then saturating restoring division
  logic [S43_W-1:0]        s43_r;
  logic [DEN_W-1:0]        den_e_r;
  logic [NUM_W-1:0]        acc_r;
  logic [SCALE_W-1:0]      sc_r;
  logic [REM_W-1:0]        rem_r;
  logic [REM_W-1:0]        dsh_r;
  logic [QUO_BITS-1:0]     quo_r;
  logic                    sat_r;
  logic signed [CODE_W-1:0] vcode_r, dcode_r;

  logic [S43_W-1:0]        s_ext;
  logic [DEN_W-1:0]        den_v;
  logic [DEN_W-1:0]        den_sel;
  logic                    rem_ge;
  logic signed [CODE_W-1:0] code_c;

  assign s_ext   = S43_W'(sum_r[SUM_W-2:0]);
  assign den_v   = DEN_W'(VIL_DIV) << POWER_FRACTION_BITS;
  assign den_sel = (cmd.sel == SEL_DENS) ? den_e_r : den_v;
  assign rem_ge  = (rem_r >= dsh_r);
  assign code_c  = sat_r ? CODE_MAX : $signed({1'b0, quo_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      s43_r   <= (s_ext << 5) + (s_ext << 3) + (s_ext << 1) + s_ext;
      den_e_r <= (DEN_W'(used_r[THK_W-2:0]) * DEN_W'(DENS_DIV)) << POWER_FRACTION_BITS;
    end
    if (cmd.mstart) begin
      acc_r <= '0;
      sc_r  <= cmd.mstart_dens ? density_scale_r : vil_gain_r;
    end else if (cmd.mstep) begin
      acc_r <= (acc_r << 1) + (sc_r[SCALE_W-1] ? NUM_W'(s43_r) : '0);
      sc_r  <= sc_r << 1;
    end
    if (cmd.dstart) begin
      // add half the divisor for round half up
      rem_r <= REM_W'(acc_r) + REM_W'(den_sel >> 1);
      dsh_r <= REM_W'(den_sel) << QUO_BITS;
      quo_r <= '0;
      sat_r <= 1'b0;
    end else if (cmd.dsat) begin
      if (rem_ge) begin
        sat_r <= 1'b1;
      end
      dsh_r <= dsh_r >> 1;
    end else if (cmd.dstep) begin
      if (rem_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[QUO_BITS-2:0], rem_ge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.save) begin
      if (cmd.sel == SEL_DENS) begin
        dcode_r <= code_c;
      end else begin
        vcode_r <= code_c;
      end
    end
  end

  // output word register
  logic signed [CODE_W-1:0] out_vil_code_r, out_density_code_r;
  logic                     out_vil_present_r, out_density_present_r;
  logic                     vil_ok, dens_ok;

  assign vil_ok  = echo_r && st.sum_pos;
  assign dens_ok = vil_ok && st.used_pos;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vil_code_r        <= vil_ok ? vcode_r : vil_miss_r;
      out_density_code_r    <= dens_ok ? dcode_r : dens_miss_r;
      out_vil_present_r     <= vil_ok;
      out_density_present_r <= dens_ok;
    end
  end

  assign out_vil_code        = out_vil_code_r;
  assign out_density_code    = out_density_code_r;
  assign out_vil_present     = out_vil_present_r;
  assign out_density_present = out_density_present_r;

  assign st.fill_last  = (fill_t_r == FILL_LAST);
  assign st.item_last  = last_item_r;
  assign st.echo_found = echo_r;
  assign st.sum_pos    = !sum_r[SUM_W-1] && (sum_r != '0);
  assign st.used_pos   = !used_r[THK_W-1] && (used_r != '0);

endmodule

[rtl/core/column_vil_and_density.sv]
// ----------------------------------------------------------------------------
// column_vil_and_density
// Each level word is taken while idle, then the input stalls in the lookup
// and accumulate states. Column end runs, for VIL and then density, a 10-step
// serial scale multiply and a saturating restoring divide (none without echo),
// then the word is held in an output register while the next column loads.
// After reset the 512-entry power table is built with the input stalled.
// ----------------------------------------------------------------------------
module column_vil_and_density
  import cvd_pkg::*;
#(
  parameter int MAX_LEVELS          = 32,
  parameter int POWER_FRACTION_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CODE_W-1:0] in_dbz_tenths,
  input  logic [HEIGHT_W-1:0]      in_level_height_m,
  input  logic [HEIGHT_W-1:0]      in_terrain_height_m,
  input  logic                     in_last_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CODE_W-1:0] out_vil_code,
  output logic signed [CODE_W-1:0] out_density_code,
  output logic                     out_vil_present,
  output logic                     out_density_present,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CODE_W-1:0]        cfg_data
);

  cvd_cmd_t    cmd;
  cvd_status_t st;

  assign cfg_ready = 1'b1;

  cvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  cvd_datapath #(
    .MAX_LEVELS         (MAX_LEVELS),
    .POWER_FRACTION_BITS(POWER_FRACTION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_dbz_tenths      (in_dbz_tenths),
    .in_level_height_m  (in_level_height_m),
    .in_terrain_height_m(in_terrain_height_m),
    .in_last_level      (in_last_level),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_vil_code       (out_vil_code),
    .out_density_code   (out_density_code),
    .out_vil_present    (out_vil_present),
    .out_density_present(out_density_present)
  );

endmodule

[rtl/core/cvd_checker.sv]
// ----------------------------------------------------------------------------
// cvd_checker
// Port-level checks on the column VIL and density block.
// ----------------------------------------------------------------------------
module cvd_checker
  import cvd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [CODE_W-1:0] out_vil_code,
  input logic signed [CODE_W-1:0] out_density_code,
  input logic                     out_vil_present,
  input logic                     out_density_present
);

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vil_code)
      && $stable(out_density_code) && $stable(out_vil_present)
      && $stable(out_density_present))
    else $error("output word changed while stalled");

  // one level in flight at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_dens_needs_vil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_density_present |-> out_vil_present)
    else $error("density present without vil");

  a_vil_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vil_present |-> !out_vil_code[CODE_W-1])
    else $error("present vil code negative");

  a_dens_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_density_present |-> !out_density_code[CODE_W-1])
    else $error("present density code negative");

endmodule

bind column_vil_and_density cvd_checker u_checker (.*);
